// ===== src/cgm_pkg.sv =====
package cgm_pkg;

  localparam int MAX_NODES_DEF = 256;

  localparam int COEF_W   = 16;
  localparam int NODE_W   = 9;
  localparam int IDX_W    = 8;
  localparam int STAT_W   = 2;
  localparam int MODE_W   = 2;
  localparam int RESULT_W = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DIAG  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIAG       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONV       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIV        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHAIN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NOSHARE    = 3'd6;

endpackage

// ===== src/correlated_gaussian_matrix_builder_unit.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    in_mode, in_row, in_col, in_sample
// out       output     out_valid/out_ready  out_status, out_weight
// cfg       input      cfg_we (no stall)    cfg_index, cfg_data
//
// One transaction in flight. Add makes two read-modify-write passes through
// the weight memory, read makes two totals reads, then four products through
// one shared multiplier; rejects go straight to the response state.
// Clear, and the pass after reset, sweep 2**(2*clog2(MAX_NODES)) weight entries,
// one entry per cycle; in_ready stays low meanwhile, config writes still land.
// A finished result waits in the output register while the next transaction
// is accepted; the block stalls only when a second result is ready.
module correlated_gaussian_matrix_builder_unit #(
  parameter int MAX_NODES = cgm_pkg::MAX_NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cgm_pkg::MODE_W-1:0]      in_mode,
  input  logic [cgm_pkg::IDX_W-1:0]       in_row,
  input  logic [cgm_pkg::IDX_W-1:0]       in_col,
  input  logic signed [cgm_pkg::COEF_W-1:0] in_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cgm_pkg::STAT_W-1:0]      out_status,
  output logic signed [cgm_pkg::RESULT_W-1:0] out_weight,
  input  logic                            cfg_we,
  input  logic [cgm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cgm_pkg::COEF_W-1:0]      cfg_data
);

  import cgm_pkg::*;

  localparam int IW = $clog2(MAX_NODES);
  localparam int AW = 2 * IW;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_S1, ST_S2, ST_S3, ST_R1, ST_R2, ST_R3, ST_RM, ST_FIN, ST_RESP
  } state_t;

  // Saturate a 64-bit signed value to w bits, kept sign-extended in 64 bits.
  function automatic logic signed [63:0] clamp(input logic signed [63:0] v, input int w);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Configuration registers
  logic [NODE_W-1:0]        node_count_r;
  logic signed [COEF_W-1:0] dg_r, rc_r, cv_r, dv_r, ch_r, ns_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_W'(256);
      dg_r <= 16'sd4096;
      rc_r <= '0;
      cv_r <= '0;
      dv_r <= '0;
      ch_r <= '0;
      ns_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_COUNT: node_count_r <= cfg_data[NODE_W-1:0];
        REG_DIAG:       dg_r <= cfg_data;
        REG_RECIP:      rc_r <= cfg_data;
        REG_CONV:       cv_r <= cfg_data;
        REG_DIV:        dv_r <= cfg_data;
        REG_CHAIN:      ch_r <= cfg_data;
        REG_NOSHARE:    ns_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Combined forward and reverse coefficients, retimed off the config path
  logic signed [18:0] a_r, b_r;
  always_ff @(posedge clk) begin
    a_r <= 19'(dg_r) - 19'(cv_r) - 19'(dv_r) + 19'(ns_r);
    b_r <= 19'(rc_r) - (19'(ch_r) <<< 1) + 19'(ns_r);
  end

  // Range check against the effective node count
  logic [31:0] n_lim;
  logic        in_bad, in_diag;
  assign n_lim = (32'(node_count_r) > 32'(MAX_NODES)) ? 32'(MAX_NODES) : 32'(node_count_r);
  assign in_bad  = (32'(in_row) >= n_lim) || (32'(in_col) >= n_lim);
  assign in_diag = (in_row == in_col);

  state_t                state_r;
  logic [AW-1:0]         clr_cnt_r;
  logic                  pend_r;
  logic [IW-1:0]         r_r, c_r;
  logic signed [15:0]    s_r;
  logic signed [34:0]    pa_r, pb_r;
  logic signed [39:0]    total_r;
  logic signed [31:0]    w_hold_r, rr_r, cc_r;
  logic signed [32:0]    xsum_r;
  logic signed [63:0]    acc_r;
  logic signed [58:0]    mul_r;
  logic [2:0]            k_r;
  logic [STAT_W-1:0]     status_r;
  logic signed [RESULT_W-1:0] res_r;
  logic                  out_valid_r;
  logic [STAT_W-1:0]     out_status_r;
  logic signed [RESULT_W-1:0] out_weight_r;

  // Memory ports
  logic              w_we, rt_we, ct_we;
  logic [AW-1:0]     w_waddr, w_raddr;
  logic [31:0]       w_wdata, rt_wdata, ct_wdata;
  logic [31:0]       w_q, rt_q, ct_q;
  logic [IW-1:0]     rt_waddr, rt_raddr, ct_waddr, ct_raddr;
  logic signed [63:0] w_upd;

  assign w_upd = 64'(signed'(w_q)) + ((state_r == ST_S2) ? 64'(pa_r) : 64'(pb_r));

  always_comb begin
    w_we    = (state_r == ST_CLR) || (state_r == ST_S2) || (state_r == ST_S3);
    w_waddr = (state_r == ST_CLR) ? clr_cnt_r :
              (state_r == ST_S2)  ? {r_r, c_r} : {c_r, r_r};
    w_wdata = (state_r == ST_CLR) ? '0 : 32'(clamp(w_upd, 32));
    w_raddr = (state_r == ST_S2) ? {c_r, r_r} : {r_r, c_r};

    rt_we    = (state_r == ST_CLR) || (state_r == ST_S2);
    rt_waddr = (state_r == ST_CLR) ? clr_cnt_r[IW-1:0] : r_r;
    rt_wdata = (state_r == ST_CLR) ? '0 :
               32'(clamp(64'(signed'(rt_q)) + 64'(s_r), 32));
    rt_raddr = (state_r == ST_R2) ? c_r : r_r;

    ct_we    = rt_we;
    ct_waddr = (state_r == ST_CLR) ? clr_cnt_r[IW-1:0] : c_r;
    ct_wdata = (state_r == ST_CLR) ? '0 :
               32'(clamp(64'(signed'(ct_q)) + 64'(s_r), 32));
    ct_raddr = (state_r == ST_R2) ? r_r : c_r;
  end

  cgm_ram #(.ADDR_W(AW), .DATA_W(32)) u_wmem (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr), .rdata(w_q)
  );
  cgm_ram #(.ADDR_W(IW), .DATA_W(32)) u_rmem (
    .clk(clk), .we(rt_we), .waddr(rt_waddr), .wdata(rt_wdata), .raddr(rt_raddr), .rdata(rt_q)
  );
  cgm_ram #(.ADDR_W(IW), .DATA_W(32)) u_cmem (
    .clk(clk), .we(ct_we), .waddr(ct_waddr), .wdata(ct_wdata), .raddr(ct_raddr), .rdata(ct_q)
  );

  // Shared multiplier for the read corrections
  logic signed [17:0] opa;
  logic signed [40:0] opb;
  logic signed [58:0] prod;
  always_comb begin
    unique case (k_r)
      3'd0: begin opa = 18'(cv_r) - 18'(ns_r); opb = 41'(rr_r); end
      3'd1: begin opa = 18'(dv_r) - 18'(ns_r); opb = 41'(cc_r); end
      3'd2: begin opa = 18'(ch_r) - 18'(ns_r); opb = 41'(xsum_r); end
      3'd3: begin opa = 18'(ns_r); opb = 41'(total_r); end
      default: begin opa = '0; opb = '0; end
    endcase
    prod = opa * opb;
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once taken; the response state reloads it itself
      if (out_ready && (state_r != ST_RESP)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (&clr_cnt_r) begin
            pend_r  <= 1'b0;
            state_r <= pend_r ? ST_RESP : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            r_r      <= IW'(in_row);
            c_r      <= IW'(in_col);
            s_r      <= in_sample;
            status_r <= STAT_OK;
            res_r    <= '0;
            if (in_mode == MODE_CLEAR) begin
              clr_cnt_r <= '0;
              total_r   <= '0;
              pend_r    <= 1'b1;
              state_r   <= ST_CLR;
            end else if (in_mode == MODE_ADD || in_mode == MODE_READ) begin
              if (in_bad) begin
                status_r <= STAT_RANGE;
                state_r  <= ST_RESP;
              end else if (in_diag) begin
                status_r <= STAT_DIAG;
                state_r  <= ST_RESP;
              end else begin
                state_r <= (in_mode == MODE_ADD) ? ST_S1 : ST_R1;
              end
            end else begin
              state_r <= ST_RESP;
            end
          end
        end
        ST_S1: begin
          pa_r    <= s_r * a_r;
          pb_r    <= s_r * b_r;
          state_r <= ST_S2;
        end
        ST_S2: begin
          total_r <= 40'(clamp(64'(total_r) + 64'(s_r), 40));
          state_r <= ST_S3;
        end
        ST_S3: state_r <= ST_RESP;
        ST_R1: state_r <= ST_R2;
        ST_R2: begin
          w_hold_r <= w_q;
          rr_r     <= rt_q;
          cc_r     <= ct_q;
          state_r  <= ST_R3;
        end
        ST_R3: begin
          xsum_r  <= 33'(signed'(rt_q)) + 33'(signed'(ct_q));
          acc_r   <= 64'(w_hold_r);
          mul_r   <= '0;
          k_r     <= '0;
          state_r <= ST_RM;
        end
        ST_RM: begin
          // accumulate the previous product, launch the next one
          acc_r <= acc_r + 64'(mul_r);
          mul_r <= (k_r < 3'd4) ? prod : '0;
          k_r   <= k_r + 1'b1;
          if (k_r == 3'd4) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          res_r   <= RESULT_W'(clamp(acc_r, RESULT_W));
          state_r <= ST_RESP;
        end
        ST_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_weight_r <= res_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_weight = out_weight_r;

endmodule

// ===== src/cgm_ram.sv =====
module cgm_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import cgm_pkg::*;

  localparam int NODES = MAX_NODES_DEF;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic signed [COEF_W-1:0] sample;
  } entry_op_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic signed [RESULT_W-1:0] weight;
  } entry_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [MODE_W-1:0] in_mode = '0;
  logic [IDX_W-1:0] in_row = '0;
  logic [IDX_W-1:0] in_col = '0;
  logic signed [COEF_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic signed [RESULT_W-1:0] out_weight;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  correlated_gaussian_matrix_builder_unit dut (.*);

  // Shadow copy of the block: registers and accumulated matrix state
  logic [NODE_W-1:0] node_reg;
  logic signed [COEF_W-1:0] diag_reg, recip_reg, conv_reg, div_reg, chain_reg, noshare_reg;
  longint weight_mem[NODES*NODES];
  longint row_sum[NODES];
  longint col_sum[NODES];
  longint sample_sum;

  entry_op_t pending_ops[$];
  entry_result_t expected_results[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  longint cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic void wipe_matrix();
    foreach (weight_mem[k]) weight_mem[k] = 0;
    foreach (row_sum[k]) row_sum[k] = 0;
    foreach (col_sum[k]) col_sum[k] = 0;
    sample_sum = 0;
  endfunction

  // Advance the shadow state by one op and queue the result it must produce
  function automatic void predict_entry(entry_op_t op);
    entry_result_t res;
    longint s, a, b, v, lim;
    int r, c;
    res = '0;
    s = longint'(op.sample);
    r = op.row;
    c = op.col;
    lim = (node_reg > NODES) ? NODES : node_reg;
    if (op.mode == MODE_CLEAR) begin
      wipe_matrix();
    end else if (op.mode == MODE_ADD || op.mode == MODE_READ) begin
      if (r >= lim || c >= lim) begin
        res.status = STAT_RANGE;
      end else if (r == c) begin
        res.status = STAT_DIAG;
      end else if (op.mode == MODE_ADD) begin
        a = longint'(diag_reg) - conv_reg - div_reg + noshare_reg;
        b = longint'(recip_reg) - 2 * longint'(chain_reg) + noshare_reg;
        weight_mem[r*NODES+c] = clamp(weight_mem[r*NODES+c] + s * a, 32);
        weight_mem[c*NODES+r] = clamp(weight_mem[c*NODES+r] + s * b, 32);
        row_sum[r] = clamp(row_sum[r] + s, 32);
        col_sum[c] = clamp(col_sum[c] + s, 32);
        sample_sum = clamp(sample_sum + s, 40);
      end else begin
        v = weight_mem[r*NODES+c];
        v += (longint'(conv_reg) - noshare_reg) * row_sum[r];
        v += (longint'(div_reg) - noshare_reg) * col_sum[c];
        v += (longint'(chain_reg) - noshare_reg) * (row_sum[c] + col_sum[r]);
        v += longint'(noshare_reg) * sample_sum;
        res.weight = clamp(v, 48);
      end
    end
    expected_results.push_back(res);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
  endtask

  // Driver: hold the payload while stalled, otherwise pull the next op or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_entry({in_mode, in_row, in_col, in_sample});
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        entry_op_t op;
        op = pending_ops.pop_front();
        in_mode <= op.mode;
        in_row <= op.row;
        in_col <= op.col;
        in_sample <= op.sample;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transaction against the oldest expectation
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL correlated_gaussian_matrix_builder_unit");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_status, 0);
      end else begin
        entry_result_t want;
        want = expected_results.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_weight !== want.weight) report_mismatch("weight", out_weight, want.weight);
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[COEF_W-1:0];
    case (idx)
      REG_NODE_COUNT: node_reg = value[NODE_W-1:0];
      REG_DIAG:       diag_reg = value[COEF_W-1:0];
      REG_RECIP:      recip_reg = value[COEF_W-1:0];
      REG_CONV:       conv_reg = value[COEF_W-1:0];
      REG_DIV:        div_reg = value[COEF_W-1:0];
      REG_CHAIN:      chain_reg = value[COEF_W-1:0];
      REG_NOSHARE:    noshare_reg = value[COEF_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sample at the falling edge so driver and monitor updates have settled
  task automatic drain();
    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic entry_op_t make_op(logic [MODE_W-1:0] m, int r, int c, int s);
    entry_op_t op;
    op.mode = m;
    op.row = r[IDX_W-1:0];
    op.col = c[IDX_W-1:0];
    op.sample = s[COEF_W-1:0];
    return op;
  endfunction

  // Pick a node index: mostly a small hot set inside the matrix so sums
  // build up and saturate, sometimes anywhere in the field
  function automatic int pick_node(int lim);
    int k;
    k = $urandom_range(99);
    if (k < 10) return $urandom_range(255);
    if (k < 70) return $urandom_range((lim < 6) ? lim - 1 : 5);
    if (k < 80) return lim - 1 - $urandom_range(lim > 1 ? 1 : 0);
    return $urandom_range(lim - 1);
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(9))
      0: return 32767;
      1: return -32768;
      2: return $urandom_range(8) - 4;
      default: return $urandom_range(65535);
    endcase
  endfunction

  task automatic run_phase(int nodes, int dg, int rc, int cv, int dv, int ch, int ns,
                           int idle, int stall, int count, bit wipe);
    int lim, k;
    drain();
    write_reg(REG_NODE_COUNT, nodes);
    write_reg(REG_DIAG, dg);
    write_reg(REG_RECIP, rc);
    write_reg(REG_CONV, cv);
    write_reg(REG_DIV, dv);
    write_reg(REG_CHAIN, ch);
    write_reg(REG_NOSHARE, ns);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    lim = (nodes > NODES) ? NODES : nodes;
    if (wipe) pending_ops.push_back(make_op(MODE_CLEAR, $urandom_range(255),
                                            $urandom_range(255), pick_sample()));
    repeat (count) begin
      k = $urandom_range(99);
      if (k < 50)
        pending_ops.push_back(make_op(MODE_ADD, pick_node(lim), pick_node(lim), pick_sample()));
      else if (k < 96)
        pending_ops.push_back(make_op(MODE_READ, pick_node(lim), pick_node(lim),
                                      $urandom_range(65535)));
      else
        pending_ops.push_back(make_op(MODE_SPARE, $urandom_range(255), $urandom_range(255),
                                      $urandom_range(65535)));
    end
  endtask

  function automatic int any_coef();
    return $urandom_range(65535);
  endfunction

  initial begin
    node_reg = NODES;
    diag_reg = 16'sd4096;
    recip_reg = '0;
    conv_reg = '0;
    div_reg = '0;
    chain_reg = '0;
    noshare_reg = '0;
    wipe_matrix();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes of samples and indexes, diagonal, spare mode, clear
    pending_ops.push_back(make_op(MODE_READ, 0, 1, 0));
    pending_ops.push_back(make_op(MODE_ADD, 0, 1, 32767));
    pending_ops.push_back(make_op(MODE_ADD, 0, 1, -32768));
    pending_ops.push_back(make_op(MODE_ADD, 255, 254, -32768));
    pending_ops.push_back(make_op(MODE_ADD, 254, 255, 32767));
    pending_ops.push_back(make_op(MODE_READ, 0, 1, 0));
    pending_ops.push_back(make_op(MODE_READ, 1, 0, 0));
    pending_ops.push_back(make_op(MODE_READ, 255, 254, 0));
    pending_ops.push_back(make_op(MODE_ADD, 7, 7, 1234));
    pending_ops.push_back(make_op(MODE_READ, 255, 255, 0));
    pending_ops.push_back(make_op(MODE_SPARE, 255, 0, -1));
    pending_ops.push_back(make_op(MODE_CLEAR, 3, 4, 5));
    pending_ops.push_back(make_op(MODE_READ, 254, 255, 0));
    drain();
    write_reg(REG_NODE_COUNT, 4);
    write_reg(REG_NOSHARE, 32767);
    write_reg(REG_CHAIN, -32768);
    pending_ops.push_back(make_op(MODE_ADD, 3, 0, 32767));
    pending_ops.push_back(make_op(MODE_ADD, 4, 0, 100));
    pending_ops.push_back(make_op(MODE_READ, 0, 4, 0));
    pending_ops.push_back(make_op(MODE_READ, 0, 3, 0));
    pending_ops.push_back(make_op(MODE_READ, 2, 1, 0));

    run_phase(256, any_coef(), any_coef(), any_coef(), any_coef(), any_coef(), any_coef(),
              0, 0, 350, 1'b0);
    run_phase(2, 32767, 32767, -32768, -32768, -32768, 32767, 61, 0, 300, 1'b1);
    run_phase(511, -32768, -32768, -32768, -32768, -32768, -32768, 0, 61, 350, 1'b0);
    run_phase(17, any_coef(), any_coef(), any_coef(), any_coef(), any_coef(), any_coef(),
              24, 24, 350, 1'b1);
    run_phase(300, any_coef(), any_coef(), any_coef(), any_coef(), any_coef(), any_coef(),
              61, 0, 300, 1'b0);
    run_phase(100, 0, 4096, 32767, 1, 32767, -1, 0, 61, 300, 1'b1);
    drain();

    if (mismatches == 0) begin
      $display("PASS correlated_gaussian_matrix_builder_unit");
    end else begin
      $display("FAIL correlated_gaussian_matrix_builder_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/cgm_pkg.sv
src/cgm_ram.sv
src/correlated_gaussian_matrix_builder_unit.sv
tb/testbench.sv
